@@ hw/rtl/lrbs_pkg.sv @@
package lrbs_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  // register indexes on the configuration channel
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHECK_PERIOD   = 8'd0,
    REG_INITIAL_DELAY  = 8'd1,
    REG_MAX_DELAY      = 8'd2,
    REG_MAX_ATTEMPTS   = 8'd3,
    REG_LONG_WAIT      = 8'd4,
    REG_ATTEMPT_TMO    = 8'd5,
    REG_PORTAL_TMO     = 8'd6,
    REG_STABLE_WINDOW  = 8'd7
  } lrbs_reg_t;

  localparam logic [15:0] RST_CHECK_PERIOD  = 16'd5000;
  localparam logic [15:0] RST_INITIAL_DELAY = 16'd500;
  localparam logic [19:0] RST_MAX_DELAY     = 20'd8000;
  localparam logic [7:0]  RST_MAX_ATTEMPTS  = 8'd10;
  localparam logic [23:0] RST_LONG_WAIT     = 24'd60000;
  localparam logic [15:0] RST_ATTEMPT_TMO   = 16'd5000;
  localparam logic [23:0] RST_PORTAL_TMO    = 24'd180000;
  localparam logic [23:0] RST_STABLE_WINDOW = 24'd30000;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_LOST      = 4'd1,
    EV_RESTORED  = 4'd2,
    EV_ATTEMPT   = 4'd3,
    EV_TIMEOUT   = 4'd4,
    EV_EXHAUSTED = 4'd5,
    EV_NOCREDS   = 4'd6,
    EV_PORTAL    = 4'd7,
    EV_MANUAL    = 4'd8
  } lrbs_event_t;

  typedef struct packed {
    logic [15:0] check_period_ms;
    logic [15:0] initial_delay_ms;
    logic [19:0] max_delay_ms;
    logic [7:0]  max_attempts;
    logic [23:0] long_wait_ms;
    logic [15:0] attempt_timeout_ms;
    logic [23:0] portal_timeout_ms;
    logic [23:0] stable_window_ms;
  } lrbs_cfg_t;

  typedef struct packed {
    logic req_type;
    logic link_up;
    logic portal_active;
    logic creds_present;
  } lrbs_in_t;

  typedef struct packed {
    logic        start_attempt;
    logic        start_portal;
    logic        drop_link;
    logic        sync_time;
    lrbs_event_t event_code;
    logic [7:0]  attempt_count;
    logic [23:0] retry_delay_ms;
    logic        reconnecting;
    logic        link_stable;
    logic [31:0] disconnect_total;
  } lrbs_out_t;

  // supervisor state apart from the time stamps
  typedef struct packed {
    logic [23:0] retry_delay;
    logic [7:0]  attempts_made;
    logic [31:0] drops_seen;
    logic        auto_retry_on;
    logic        prev_link_up;
    logic        attempt_running;
    logic        drop_valid;
  } lrbs_state_t;

endpackage

@@ hw/rtl/lrbs_in_if.sv @@
interface lrbs_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic link_up;
  logic portal_active;
  logic creds_present;

  modport source (output valid, req_type, link_up, portal_active, creds_present,
                  input ready);
  modport sink (input valid, req_type, link_up, portal_active, creds_present,
                output ready);
endinterface

@@ hw/rtl/lrbs_out_if.sv @@
interface lrbs_out_if;
  import lrbs_pkg::*;
  logic        valid;
  logic        ready;
  logic        start_attempt;
  logic        start_portal;
  logic        drop_link;
  logic        sync_time;
  logic [3:0]  event_code;
  logic [7:0]  attempt_count;
  logic [23:0] retry_delay_ms;
  logic        reconnecting;
  logic        link_stable;
  logic [31:0] disconnect_total;

  modport source (output valid, start_attempt, start_portal, drop_link, sync_time,
                  event_code, attempt_count, retry_delay_ms, reconnecting,
                  link_stable, disconnect_total,
                  input ready);
  modport sink (input valid, start_attempt, start_portal, drop_link, sync_time,
                event_code, attempt_count, retry_delay_ms, reconnecting,
                link_stable, disconnect_total,
                output ready);
endinterface

@@ hw/rtl/lrbs_cfg_if.sv @@
interface lrbs_cfg_if;
  import lrbs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/lrbs_cfg_regs.sv @@
module lrbs_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  lrbs_cfg_if.sink           cfg_ch,
  output lrbs_pkg::lrbs_cfg_t cfg
);
  import lrbs_pkg::*;

  lrbs_cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_period_ms    <= RST_CHECK_PERIOD;
      cfg_r.initial_delay_ms   <= RST_INITIAL_DELAY;
      cfg_r.max_delay_ms       <= RST_MAX_DELAY;
      cfg_r.max_attempts       <= RST_MAX_ATTEMPTS;
      cfg_r.long_wait_ms       <= RST_LONG_WAIT;
      cfg_r.attempt_timeout_ms <= RST_ATTEMPT_TMO;
      cfg_r.portal_timeout_ms  <= RST_PORTAL_TMO;
      cfg_r.stable_window_ms   <= RST_STABLE_WINDOW;
    end else if (cfg_ch.valid) begin
      // indexes past the list are dropped
      case (cfg_ch.index)
        REG_CHECK_PERIOD:  cfg_r.check_period_ms    <= cfg_ch.data[15:0];
        REG_INITIAL_DELAY: cfg_r.initial_delay_ms   <= cfg_ch.data[15:0];
        REG_MAX_DELAY:     cfg_r.max_delay_ms       <= cfg_ch.data[19:0];
        REG_MAX_ATTEMPTS:  cfg_r.max_attempts       <= cfg_ch.data[7:0];
        REG_LONG_WAIT:     cfg_r.long_wait_ms       <= cfg_ch.data[23:0];
        REG_ATTEMPT_TMO:   cfg_r.attempt_timeout_ms <= cfg_ch.data[15:0];
        REG_PORTAL_TMO:    cfg_r.portal_timeout_ms  <= cfg_ch.data[23:0];
        REG_STABLE_WINDOW: cfg_r.stable_window_ms   <= cfg_ch.data[23:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/lrbs_step.sv @@
module lrbs_step #(
  parameter int TIME_BITS = 32
) (
  input  lrbs_pkg::lrbs_in_t    item,
  input  lrbs_pkg::lrbs_cfg_t   cfg,
  input  lrbs_pkg::lrbs_state_t st,
  input  logic [TIME_BITS-1:0]  clock_ms,
  input  logic [TIME_BITS-1:0]  last_sample_ms,
  input  logic [TIME_BITS-1:0]  last_drop_ms,
  input  logic [TIME_BITS-1:0]  attempt_begin_ms,
  output lrbs_pkg::lrbs_state_t st_nxt,
  output logic [TIME_BITS-1:0]  clock_ms_nxt,
  output logic [TIME_BITS-1:0]  last_sample_ms_nxt,
  output logic [TIME_BITS-1:0]  last_drop_ms_nxt,
  output logic [TIME_BITS-1:0]  attempt_begin_ms_nxt,
  output lrbs_pkg::lrbs_out_t   res
);
  import lrbs_pkg::*;

  localparam int TW = TIME_BITS;

  lrbs_state_t      s;
  lrbs_event_t      ev;
  logic [TW-1:0]    now;
  logic [TW-1:0]    ld;
  logic [TW-1:0]    el;
  logic [24:0]      dbl;
  logic             cur;
  logic             start;
  logic             portal;
  logic             stable;

  always_comb begin
    s      = st;
    ev     = EV_NONE;
    now    = clock_ms;
    ld     = last_drop_ms;
    el     = '0;
    dbl    = '0;
    cur    = item.link_up;
    start  = 1'b0;
    portal = 1'b0;
    last_sample_ms_nxt   = last_sample_ms;
    attempt_begin_ms_nxt = attempt_begin_ms;

    if (item.req_type) begin
      // manual reconnect: clock stays, next tick may attempt at once
      s.attempts_made   = '0;
      s.retry_delay     = 24'(cfg.initial_delay_ms);
      s.attempt_running = 1'b0;
      s.auto_retry_on   = 1'b1;
      ld                = clock_ms - TW'(cfg.initial_delay_ms);
      s.drop_valid      = 1'b1;
      ev                = EV_MANUAL;
    end else begin
      now = clock_ms + TW'(1);

      // periodic link sample
      el = now - last_sample_ms;
      if (el > TW'(cfg.check_period_ms)) begin
        last_sample_ms_nxt = now;
        if (!cur && s.prev_link_up) begin
          ld                = now;
          s.drop_valid      = 1'b1;
          s.drops_seen      = s.drops_seen + 32'd1;
          s.retry_delay     = 24'(cfg.initial_delay_ms);
          s.attempts_made   = '0;
          s.auto_retry_on   = 1'b1;
          s.attempt_running = 1'b0;
          ev                = EV_LOST;
        end
        if (cur && !s.prev_link_up) begin
          s.auto_retry_on = 1'b0;
          s.attempts_made = '0;
          s.retry_delay   = 24'(cfg.initial_delay_ms);
          ev              = EV_RESTORED;
        end
        s.prev_link_up = cur;
      end

      // backoff
      el = now - ld;
      if (!cur && s.auto_retry_on && el >= TW'(s.retry_delay)) begin
        if (s.attempts_made >= cfg.max_attempts) begin
          ld                = now;
          s.drop_valid      = 1'b1;
          s.retry_delay     = cfg.long_wait_ms;
          s.attempts_made   = '0;
          s.attempt_running = 1'b0;
          ev                = EV_EXHAUSTED;
        end else if (!s.attempt_running) begin
          s.attempts_made = s.attempts_made + 8'd1;
          if (!item.creds_present) begin
            s.auto_retry_on = 1'b0;
            ev              = EV_NOCREDS;
          end else begin
            start                = 1'b1;
            s.attempt_running    = 1'b1;
            attempt_begin_ms_nxt = now;
            ev                   = EV_ATTEMPT;
          end
        end else if ((now - attempt_begin_ms) >= TW'(cfg.attempt_timeout_ms)) begin
          dbl               = {s.retry_delay, 1'b0};
          s.retry_delay     = (dbl < 25'(cfg.max_delay_ms)) ? dbl[23:0]
                                                            : 24'(cfg.max_delay_ms);
          ld                = now;
          s.drop_valid      = 1'b1;
          s.attempt_running = 1'b0;
          ev                = EV_TIMEOUT;
        end
      end

      // long outage asks for the setup portal
      el = now - ld;
      if (!cur && !item.portal_active && s.drop_valid &&
          el > TW'(cfg.portal_timeout_ms)) begin
        portal          = 1'b1;
        s.auto_retry_on = 1'b0;
        ev              = EV_PORTAL;
      end
    end

    el     = now - ld;
    stable = cur && !s.auto_retry_on && (el > TW'(cfg.stable_window_ms));

    st_nxt           = s;
    clock_ms_nxt     = now;
    last_drop_ms_nxt = ld;

    res.start_attempt    = start;
    res.start_portal     = portal;
    res.drop_link        = item.req_type;
    res.sync_time        = (ev == EV_RESTORED);
    res.event_code       = ev;
    res.attempt_count    = s.attempts_made;
    res.retry_delay_ms   = s.retry_delay;
    res.reconnecting     = s.auto_retry_on;
    res.link_stable      = stable;
    res.disconnect_total = s.drops_seen;
  end

endmodule

@@ hw/rtl/link_reconnect_backoff_supervisor.sv @@
// channel   dir  handshake      payload
// in_ch     in   valid / ready  req_type, link_up, portal_active, creds_present
// out_ch    out  valid / ready  pulses, event_code, counters, delay, status
// cfg_ch    in   valid / ready  index (register number), data
//
// one transaction per clock sustained while out_ch is ready; a taken input passes
// through the input register, then step logic into the result register
// the step logic is a handful of time-stamp subtractors and compares in series
// reset (rst_n low, synchronous) loads the register defaults and clears state
// a stalled out_ch holds the result; in_ch keeps taking one more transaction
// into the input register and then drops ready until the result drains
// cfg_ch is always ready; writes go straight into the register bank
module link_reconnect_backoff_supervisor #(
  parameter int TIME_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lrbs_in_if.sink    in_ch,
  lrbs_out_if.source out_ch,
  lrbs_cfg_if.sink   cfg_ch
);
  import lrbs_pkg::*;

  // configuration bank
  lrbs_cfg_t cfg;

  lrbs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // input register
  logic     s1_valid_r;
  lrbs_in_t s1_item_r;

  // result register
  logic      out_valid_r;
  lrbs_out_t out_item_r;

  // supervisor state
  lrbs_state_t          st_r;
  lrbs_state_t          st_nxt;
  logic [TIME_BITS-1:0] clock_ms_r;
  logic [TIME_BITS-1:0] clock_ms_nxt;
  logic [TIME_BITS-1:0] last_sample_ms_r;
  logic [TIME_BITS-1:0] last_sample_ms_nxt;
  logic [TIME_BITS-1:0] last_drop_ms_r;
  logic [TIME_BITS-1:0] last_drop_ms_nxt;
  logic [TIME_BITS-1:0] attempt_begin_ms_r;
  logic [TIME_BITS-1:0] attempt_begin_ms_nxt;
  lrbs_out_t            res;

  logic out_load;
  logic in_take;

  // the step fires when the result register is free or being drained
  assign out_load    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || out_load;
  assign in_take     = in_ch.valid && in_ch.ready;

  lrbs_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .item                 (s1_item_r),
    .cfg                  (cfg),
    .st                   (st_r),
    .clock_ms             (clock_ms_r),
    .last_sample_ms       (last_sample_ms_r),
    .last_drop_ms         (last_drop_ms_r),
    .attempt_begin_ms     (attempt_begin_ms_r),
    .st_nxt               (st_nxt),
    .clock_ms_nxt         (clock_ms_nxt),
    .last_sample_ms_nxt   (last_sample_ms_nxt),
    .last_drop_ms_nxt     (last_drop_ms_nxt),
    .attempt_begin_ms_nxt (attempt_begin_ms_nxt),
    .res                  (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.req_type      <= in_ch.req_type;
      s1_item_r.link_up       <= in_ch.link_up;
      s1_item_r.portal_active <= in_ch.portal_active;
      s1_item_r.creds_present <= in_ch.creds_present;
    end
  end

  // state commits together with the result it produced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.retry_delay     <= 24'(RST_INITIAL_DELAY);
      st_r.attempts_made   <= '0;
      st_r.drops_seen      <= '0;
      st_r.auto_retry_on   <= 1'b0;
      st_r.prev_link_up    <= 1'b0;
      st_r.attempt_running <= 1'b0;
      st_r.drop_valid      <= 1'b0;
      clock_ms_r           <= '0;
      last_sample_ms_r     <= '0;
      last_drop_ms_r       <= '0;
      attempt_begin_ms_r   <= '0;
    end else if (out_load) begin
      st_r               <= st_nxt;
      clock_ms_r         <= clock_ms_nxt;
      last_sample_ms_r   <= last_sample_ms_nxt;
      last_drop_ms_r     <= last_drop_ms_nxt;
      attempt_begin_ms_r <= attempt_begin_ms_nxt;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.start_attempt    = out_item_r.start_attempt;
  assign out_ch.start_portal     = out_item_r.start_portal;
  assign out_ch.drop_link        = out_item_r.drop_link;
  assign out_ch.sync_time        = out_item_r.sync_time;
  assign out_ch.event_code       = out_item_r.event_code;
  assign out_ch.attempt_count    = out_item_r.attempt_count;
  assign out_ch.retry_delay_ms   = out_item_r.retry_delay_ms;
  assign out_ch.reconnecting     = out_item_r.reconnecting;
  assign out_ch.link_stable      = out_item_r.link_stable;
  assign out_ch.disconnect_total = out_item_r.disconnect_total;

  // an attempt pulse only comes with the attempt event, or the portal that overrides it
  a_start_event : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.start_attempt |->
      (out_item_r.event_code == EV_ATTEMPT) || (out_item_r.event_code == EV_PORTAL))
    else $error("start_attempt without attempt event");

  // manual request restarts the series with retry on
  a_manual : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.drop_link |->
      out_item_r.reconnecting && (out_item_r.attempt_count == 8'd0) &&
      (out_item_r.event_code == EV_MANUAL))
    else $error("manual request result inconsistent");

  // stable and reconnecting exclude each other
  a_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.link_stable |-> !out_item_r.reconnecting)
    else $error("stable while reconnecting");

  // portal request always stops automatic retry
  a_portal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.start_portal |->
      !out_item_r.reconnecting && (out_item_r.event_code == EV_PORTAL))
    else $error("portal request with retry still on");

  // state only moves when a result is produced
  a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(clock_ms_r) && $stable(st_r))
    else $error("state changed without a result");

endmodule

@@ test/lrbs_status_checker.sv @@
`timescale 1ns / 1ps

module lrbs_status_checker (
  input  logic clk,
  input  logic rst_n,
  lrbs_in_if   in_ch,
  lrbs_out_if  out_ch,
  lrbs_cfg_if  cfg_ch,
  output int   mismatches,
  output int   outstanding,
  output int   checked
);
  import lrbs_pkg::*;

  localparam int REG_COUNT   = 8;
  localparam int MAX_REPORTS = 10;

  // register bank copy, zero extended
  logic [31:0] cfg_reg [REG_COUNT];

  // supervisor state
  logic [31:0] ms_clock, sampled_at, dropped_at, attempt_at;
  logic [31:0] delay_ms;
  logic [7:0]  attempts;
  logic [31:0] drops;
  logic        auto_on, link_was_up, attempt_live, drop_seen;

  lrbs_out_t status_due [$];

  function automatic logic [31:0] reg_mask(input logic [CFG_INDEX_W-1:0] idx);
    case (idx)
      REG_MAX_DELAY:    return 32'h000F_FFFF;
      REG_MAX_ATTEMPTS: return 32'h0000_00FF;
      REG_LONG_WAIT, REG_PORTAL_TMO, REG_STABLE_WINDOW: return 32'h00FF_FFFF;
      default:          return 32'h0000_FFFF;
    endcase
  endfunction

  function automatic string show(input lrbs_out_t r);
    return {$sformatf("att_pulse=%0b portal=%0b drop=%0b sync=%0b ev=%0d ",
                      r.start_attempt, r.start_portal, r.drop_link, r.sync_time,
                      r.event_code),
            $sformatf("att=%0d dly=%0d rc=%0b stb=%0b drops=%0d",
                      r.attempt_count, r.retry_delay_ms, r.reconnecting, r.link_stable,
                      r.disconnect_total)};
  endfunction

  function automatic string wrong_fields(input lrbs_out_t want, input lrbs_out_t got);
    string s = "";
    if (got.start_attempt !== want.start_attempt) s = {s, " start_attempt"};
    if (got.start_portal !== want.start_portal) s = {s, " start_portal"};
    if (got.drop_link !== want.drop_link) s = {s, " drop_link"};
    if (got.sync_time !== want.sync_time) s = {s, " sync_time"};
    if (got.event_code !== want.event_code) s = {s, " event_code"};
    if (got.attempt_count !== want.attempt_count) s = {s, " attempt_count"};
    if (got.retry_delay_ms !== want.retry_delay_ms) s = {s, " retry_delay_ms"};
    if (got.reconnecting !== want.reconnecting) s = {s, " reconnecting"};
    if (got.link_stable !== want.link_stable) s = {s, " link_stable"};
    if (got.disconnect_total !== want.disconnect_total) s = {s, " disconnect_total"};
    return s;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("checker: %s", msg);
  endtask

  // one request through the supervisor, state updated in place
  task automatic predict_status(input lrbs_in_t req, output lrbs_out_t res);
    logic [31:0] now;
    logic [31:0] doubled;
    res = '0;
    res.event_code = EV_NONE;
    if (req.req_type) begin
      // manual reconnect: clock holds, next tick may attempt at once
      res.drop_link = 1'b1;
      attempts = '0;
      delay_ms = cfg_reg[REG_INITIAL_DELAY];
      attempt_live = 1'b0;
      auto_on = 1'b1;
      dropped_at = ms_clock - delay_ms;
      drop_seen = 1'b1;
      res.event_code = EV_MANUAL;
      now = ms_clock;
    end else begin
      now = ms_clock + 32'd1;
      ms_clock = now;
      if (now - sampled_at > cfg_reg[REG_CHECK_PERIOD]) begin
        sampled_at = now;
        if (!req.link_up && link_was_up) begin
          dropped_at = now;
          drop_seen = 1'b1;
          drops = drops + 32'd1;
          delay_ms = cfg_reg[REG_INITIAL_DELAY];
          attempts = '0;
          auto_on = 1'b1;
          attempt_live = 1'b0;
          res.event_code = EV_LOST;
        end
        if (req.link_up && !link_was_up) begin
          auto_on = 1'b0;
          attempts = '0;
          delay_ms = cfg_reg[REG_INITIAL_DELAY];
          res.sync_time = 1'b1;
          res.event_code = EV_RESTORED;
        end
        link_was_up = req.link_up;
      end
      if (!req.link_up && auto_on && now - dropped_at >= delay_ms) begin
        if (32'(attempts) >= cfg_reg[REG_MAX_ATTEMPTS]) begin
          dropped_at = now;
          drop_seen = 1'b1;
          delay_ms = cfg_reg[REG_LONG_WAIT];
          attempts = '0;
          attempt_live = 1'b0;
          res.event_code = EV_EXHAUSTED;
        end else if (!attempt_live) begin
          attempts = attempts + 8'd1;
          if (!req.creds_present) begin
            auto_on = 1'b0;
            res.event_code = EV_NOCREDS;
          end else begin
            res.start_attempt = 1'b1;
            attempt_live = 1'b1;
            attempt_at = now;
            res.event_code = EV_ATTEMPT;
          end
        end else if (now - attempt_at >= cfg_reg[REG_ATTEMPT_TMO]) begin
          doubled = {delay_ms[30:0], 1'b0};
          delay_ms = (doubled < cfg_reg[REG_MAX_DELAY]) ? doubled : cfg_reg[REG_MAX_DELAY];
          dropped_at = now;
          drop_seen = 1'b1;
          attempt_live = 1'b0;
          res.event_code = EV_TIMEOUT;
        end
      end
      if (!req.link_up && !req.portal_active && drop_seen &&
          now - dropped_at > cfg_reg[REG_PORTAL_TMO]) begin
        res.start_portal = 1'b1;
        auto_on = 1'b0;
        res.event_code = EV_PORTAL;
      end
    end
    res.attempt_count = attempts;
    res.retry_delay_ms = delay_ms[23:0];
    res.reconnecting = auto_on;
    res.link_stable = req.link_up && !auto_on &&
                      (now - dropped_at > cfg_reg[REG_STABLE_WINDOW]);
    res.disconnect_total = drops;
  endtask

  always @(posedge clk) begin : watch
    lrbs_out_t want;
    lrbs_out_t got;
    lrbs_in_t  req;
    string     bad;
    if (!rst_n) begin
      cfg_reg[REG_CHECK_PERIOD]  = 32'(RST_CHECK_PERIOD);
      cfg_reg[REG_INITIAL_DELAY] = 32'(RST_INITIAL_DELAY);
      cfg_reg[REG_MAX_DELAY]     = 32'(RST_MAX_DELAY);
      cfg_reg[REG_MAX_ATTEMPTS]  = 32'(RST_MAX_ATTEMPTS);
      cfg_reg[REG_LONG_WAIT]     = 32'(RST_LONG_WAIT);
      cfg_reg[REG_ATTEMPT_TMO]   = 32'(RST_ATTEMPT_TMO);
      cfg_reg[REG_PORTAL_TMO]    = 32'(RST_PORTAL_TMO);
      cfg_reg[REG_STABLE_WINDOW] = 32'(RST_STABLE_WINDOW);
      ms_clock = '0;
      sampled_at = '0;
      dropped_at = '0;
      attempt_at = '0;
      delay_ms = 32'(RST_INITIAL_DELAY);
      attempts = '0;
      drops = '0;
      auto_on = 1'b0;
      link_was_up = 1'b0;
      attempt_live = 1'b0;
      drop_seen = 1'b0;
      status_due.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.start_attempt    = out_ch.start_attempt;
        got.start_portal     = out_ch.start_portal;
        got.drop_link        = out_ch.drop_link;
        got.sync_time        = out_ch.sync_time;
        got.event_code       = lrbs_event_t'(out_ch.event_code);
        got.attempt_count    = out_ch.attempt_count;
        got.retry_delay_ms   = out_ch.retry_delay_ms;
        got.reconnecting     = out_ch.reconnecting;
        got.link_stable      = out_ch.link_stable;
        got.disconnect_total = out_ch.disconnect_total;
        checked++;
        if (status_due.size() == 0) begin
          note_failure($sformatf("result %0d with nothing pending: %s", checked, show(got)));
        end else begin
          want = status_due.pop_front();
          bad = wrong_fields(want, got);
          if (bad != "")
            note_failure($sformatf("result %0d wrong in%s: expected %s, got %s",
                                   checked, bad, show(want), show(got)));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < REG_COUNT)
        cfg_reg[cfg_ch.index[2:0]] = cfg_ch.data & reg_mask(cfg_ch.index);
      if (in_ch.valid && in_ch.ready) begin
        req.req_type      = in_ch.req_type;
        req.link_up       = in_ch.link_up;
        req.portal_active = in_ch.portal_active;
        req.creds_present = in_ch.creds_present;
        predict_status(req, want);
        status_due.push_back(want);
      end
    end
    outstanding <= status_due.size();
  end

endmodule

@@ test/tb_link_reconnect_backoff_supervisor.sv @@
`timescale 1ns / 1ps

module tb_link_reconnect_backoff_supervisor;
  import lrbs_pkg::*;

  // request kinds on the input channel
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_MANUAL = 1'b1;

  localparam int REG_COUNT      = 8;
  localparam int GAP_MAX        = 15;
  localparam int RX_HOLD_CYCLES = 400;  // long output stall, fills the pipeline
  localparam int DRAIN_SLACK    = 4;    // two-stage pipeline plus margin
  localparam int END_WAIT_LIMIT = 5000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  lrbs_in_if  in_ch ();
  lrbs_out_if out_ch ();
  lrbs_cfg_if cfg_ch ();

  int fail_cnt;
  int pending;
  int results_seen;

  link_reconnect_backoff_supervisor u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicts each result and compares, reports the failure count back
  lrbs_status_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (fail_cnt),
    .outstanding (pending),
    .checked     (results_seen)
  );

  // stimulus-side state
  logic [23:0] setting [REG_COUNT];
  logic        link_level = 1'b0;  // slowly toggling link for well-formed outages
  bit          tx_steady  = 1'b0;  // sender back-to-back stretch
  bit          rx_steady  = 1'b0;  // receiver always-ready stretch
  logic        rx_hold    = 1'b0;  // long receiver hold-off, own process
  int          sent       = 0;
  int          directed_n = 0;
  int          phases     = 0;

  // timeout guard, several times the slowest legal run
  initial begin
    #4_000_000;
    $display("timeout: run did not finish");
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stall per result, honors the long hold
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 59) == 0) rx_steady = ~rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0 || rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic lrbs_in_t make_req(input logic kind, input logic up,
                                        input logic portal, input logic creds);
    lrbs_in_t r;
    r.req_type      = kind;
    r.link_up       = up;
    r.portal_active = portal;
    r.creds_present = creds;
    return r;
  endfunction

  // mostly coherent outages with random content, some raw noise
  function automatic lrbs_in_t next_random_req();
    lrbs_in_t r;
    if ($urandom_range(0, 9) == 0) begin
      r = lrbs_in_t'(4'($urandom_range(0, 15)));
    end else begin
      if ($urandom_range(0, 29) == 0) link_level = ~link_level;
      r.req_type      = ($urandom_range(0, 49) == 0) ? REQ_MANUAL : REQ_TICK;
      r.link_up       = link_level;
      r.portal_active = ($urandom_range(0, 7) == 0);
      r.creds_present = ($urandom_range(0, 9) != 0);
    end
    return r;
  endfunction

  // one input transaction, random gap ahead of it
  task automatic send_req(input lrbs_in_t r);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= r.req_type;
    in_ch.link_up       <= r.link_up;
    in_ch.portal_active <= r.portal_active;
    in_ch.creds_present <= r.creds_present;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // sender pause until every result is back, then let the pipeline settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // config transaction, upper junk bits exercise the width masking
  task automatic put_register(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] value);
    logic [7:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 255)) : 8'd0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= {junk, value};
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // whole bank, sometimes followed by a write to a nonexistent register
  task automatic load_settings();
    logic [CFG_INDEX_W-1:0] idx;
    for (int r = 0; r < REG_COUNT; r++) begin
      idx = CFG_INDEX_W'(r);
      put_register(idx, setting[r]);
    end
    if ($urandom_range(0, 1) == 1) begin
      idx = REG_STABLE_WINDOW;
      idx = idx + CFG_INDEX_W'($urandom_range(1, 248));
      put_register(idx, 24'($urandom_range(0, 24'hFF_FFFF)));
    end
    cfg_ch.valid <= 1'b0;
    phases++;
  endtask

  // short timers so that outages, backoff and portal all show up in a few hundred ticks
  task automatic pick_small_settings();
    setting[REG_CHECK_PERIOD]  = 24'($urandom_range(1, 6));
    setting[REG_INITIAL_DELAY] = 24'($urandom_range(1, 8));
    setting[REG_MAX_DELAY]     = 24'($urandom_range(1, 40));
    setting[REG_MAX_ATTEMPTS]  = 24'($urandom_range(1, 5));
    setting[REG_LONG_WAIT]     = 24'($urandom_range(1, 50));
    setting[REG_ATTEMPT_TMO]   = 24'($urandom_range(1, 8));
    setting[REG_PORTAL_TMO]    = 24'($urandom_range(10, 120));
    setting[REG_STABLE_WINDOW] = 24'($urandom_range(1, 60));
  endtask

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 59) == 0) tx_steady = ~tx_steady;
      send_req(next_random_req());
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  initial begin
    // known levels on every input from time zero
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= REQ_TICK;
    in_ch.link_up       <= 1'b0;
    in_ch.portal_active <= 1'b0;
    in_ch.creds_present <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_CHECK_PERIOD;
    cfg_ch.data         <= '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: manual request at clock zero wraps the drop stamp,
    // then missing credentials, a real attempt, portal already up
    send_req(make_req(REQ_MANUAL, 1'b0, 1'b0, 1'b1));
    send_req(make_req(REQ_TICK,   1'b0, 1'b0, 1'b0));
    send_req(make_req(REQ_MANUAL, 1'b0, 1'b0, 1'b1));
    send_req(make_req(REQ_TICK,   1'b0, 1'b0, 1'b1));
    send_req(make_req(REQ_TICK,   1'b1, 1'b1, 1'b0));
    send_req(make_req(REQ_TICK,   1'b0, 1'b1, 1'b1));

    // tiny timers: restore, manual with link up, then a down stretch that
    // walks through loss, attempts, timeouts, delay cap and exhaustion
    wait_drained();
    setting[REG_CHECK_PERIOD]  = 24'd2;
    setting[REG_INITIAL_DELAY] = 24'd2;
    setting[REG_MAX_DELAY]     = 24'd5;
    setting[REG_MAX_ATTEMPTS]  = 24'd2;
    setting[REG_LONG_WAIT]     = 24'd3;
    setting[REG_ATTEMPT_TMO]   = 24'd2;
    setting[REG_PORTAL_TMO]    = 24'd14;
    setting[REG_STABLE_WINDOW] = 24'd4;
    load_settings();
    repeat (3) send_req(make_req(REQ_TICK, 1'b1, 1'b0, 1'b1));
    send_req(make_req(REQ_MANUAL, 1'b1, 1'b0, 1'b1));
    repeat (10) send_req(make_req(REQ_TICK, 1'b0, 1'b0, 1'b1));
    repeat (2) send_req(make_req(REQ_TICK, 1'b0, 1'b1, 1'b0));
    repeat (2) send_req(make_req(REQ_TICK, 1'b1, 1'b0, 1'b0));
    directed_n = sent;

    // every register at its upper bound, the maximum delay just under it
    wait_drained();
    setting[REG_CHECK_PERIOD]  = 24'd65535;
    setting[REG_INITIAL_DELAY] = 24'd65535;
    setting[REG_MAX_DELAY]     = 24'd1000000;
    setting[REG_MAX_ATTEMPTS]  = 24'd255;
    setting[REG_LONG_WAIT]     = 24'hFF_FFFF;
    setting[REG_ATTEMPT_TMO]   = 24'd65535;
    setting[REG_PORTAL_TMO]    = 24'hFF_FFFF;
    setting[REG_STABLE_WINDOW] = 24'hFF_FFFF;
    load_settings();
    run_random(100);

    // every register at its lower bound
    wait_drained();
    foreach (setting[r]) setting[r] = 24'd1;
    load_settings();
    run_random(200);

    // random short timers; one phase runs under a long output hold-off
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      pick_small_settings();
      load_settings();
      if (p == 2) begin
        fork
          run_random(280);
          begin
            rx_hold <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join
      end else begin
        run_random(280);
      end
    end

    // bounded wait for the last results, then watch for strays
    in_ch.valid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < END_WAIT_LIMIT && pending != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);

    if (pending != 0) $display("results never returned: %0d", pending);
    $display("summary: %0d requests (%0d directed), %0d results checked, %0d settings",
             sent, directed_n, results_seen, phases);
    $display("summary: extreme and random timers, one %0d-cycle output hold, drained updates",
             RX_HOLD_CYCLES);
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
